// File: src/bl2d_pkg.sv
// bl2d_pkg: widths, reset values and lookup tables for the backlight level mapper
// used by backlight_level_to_drive and its port checker
// depends on nothing
package bl2d_pkg;

	// field widths
	localparam int LVL_W   = 10;
	localparam int DUTY_W  = 10;
	localparam int PULSE_W = 5;
	localparam int CMD_W   = 8;
	localparam int SCALE_W = 7;
	localparam int MAP_W   = 8;
	localparam int PROD_W  = MAP_W + SCALE_W;

	// defaults
	localparam int LEVEL_MAX_DEF = 248;
	localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(90);

	// duty above this threshold is scaled for the panel command
	localparam logic [MAP_W-1:0] CMD_SCALE_TH = MAP_W'(32);

	// divide by 100 through multiply by reciprocal, exact for products below 43690
	localparam int RECIP_SH  = 21;
	localparam int RECIP_100 = (1 << RECIP_SH) / 100 + 1;
	localparam int MULT_W    = 2 * PROD_W;
	localparam int QUOT_W    = 9;

	// lookup tables
	localparam int DUTY_ENTRIES  = 256;
	localparam int PULSE_ENTRIES = 64;

	typedef logic [MAP_W-1:0]   duty_lut_t  [DUTY_ENTRIES];
	typedef logic [PULSE_W-1:0] pulse_lut_t [PULSE_ENTRIES];

	// piecewise-linear duty map, 0 for level zero
	function automatic duty_lut_t build_duty_lut();
		duty_lut_t lut;
		int        v;
		for (int i = 0; i < DUTY_ENTRIES; i++) begin
			if (i == 0)
				v = 0;
			else if (i <= 36)
				v = 26;
			else if (i <= 102)
				v = (489 * i + 7000) / 1000 + 1;
			else
				v = (111 * i - 5633) / 100 + 1;
			lut[i] = MAP_W'(v);
		end
		return lut;
	endfunction

	// one-wire pulse count, 1 beyond the ramp segments
	function automatic pulse_lut_t build_pulse_lut();
		pulse_lut_t lut;
		int         v;
		for (int i = 0; i < PULSE_ENTRIES; i++) begin
			if (i >= 1 && i <= 9)
				v = (320 - 16 * i) / 10;
			else if (i >= 10 && i <= 36)
				v = (23140 - 615 * i) / 1000;
			else
				v = 1;
			lut[i] = PULSE_W'(v);
		end
		return lut;
	endfunction

	localparam duty_lut_t  DUTY_LUT  = build_duty_lut();
	localparam pulse_lut_t PULSE_LUT = build_pulse_lut();

endpackage

// File: src/backlight_level_to_drive.sv
// backlight_level_to_drive: maps a backlight level request to enable line, pwm duty,
// one-wire pulse count and panel command; depends on bl2d_pkg
//
// usage:
//   input channel  in_valid/in_stall carries level; output channel out_valid/out_stall
//   carries duty, enable_line, pulse_count, cmd_valid, cmd_value and bypassed.
//   a request is taken at a rising edge with valid high and stall low.
//   the input register feeds table lookup and scale multiply into stage 2, and stage 2
//   feeds the reciprocal divide and history compare into the result register.
//   throughput is one request per cycle while the receiver does not stall; the history
//   registers (last pulse count, on flag, last command) are updated only at the last
//   stage, so back-to-back requests see each other's effects in order.
//   when the receiver stalls, the result register holds; the stages behind it keep
//   filling any empty slot, and in_stall rises once the input register cannot move.
//   reset clears all stages and the history and sets line_present to 1 and
//   cmd_scale_percent to 90.
//   configuration is an apb port: line_present at 0x0, cmd_scale_percent at 0x4;
//   write it only while no request is in flight.
module backlight_level_to_drive
	import bl2d_pkg::*;
#(
	parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// apb configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [LVL_W-1:0]   level,
	// result output
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DUTY_W-1:0]  duty,
	output logic               enable_line,
	output logic [PULSE_W-1:0] pulse_count,
	output logic               cmd_valid,
	output logic [CMD_W-1:0]   cmd_value,
	output logic               bypassed
);

	localparam logic REG_LINE_PRESENT = 1'b0;
	localparam logic REG_CMD_SCALE    = 1'b1;
	localparam logic [LVL_W-1:0] LEVEL_SAT = LVL_W'(LEVEL_MAX);

	logic               line_present_q;
	logic [SCALE_W-1:0] scale_q;

	logic               valid_s1;
	logic [LVL_W-1:0]   level_s1;

	logic               valid_s2;
	logic               byp_s2;
	logic               off_s2;
	logic               big_s2;
	logic [DUTY_W-1:0]  duty_s2;
	logic [PULSE_W-1:0] pulses_s2;
	logic [PROD_W-1:0]  prod_s2;

	logic [PULSE_W-1:0] last_pulse_q;
	logic               was_on_q;
	logic [CMD_W-1:0]   last_cmd_q;

	logic               out_adv;
	logic               load_s2;
	logic               load_s1;

	// apb register file
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_present_q <= 1'b1;
			scale_q        <= SCALE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_LINE_PRESENT: line_present_q <= pwdata[0];
				REG_CMD_SCALE:    scale_q        <= pwdata[SCALE_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LINE_PRESENT: prdata = {31'b0, line_present_q};
			REG_CMD_SCALE:    prdata = {{(32-SCALE_W){1'b0}}, scale_q};
			default:          prdata = '0;
		endcase
	end

	// pipeline flow control
	assign out_adv  = !out_valid || !out_stall;
	assign load_s2  = !valid_s2 || out_adv;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load_s1)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid)
			level_s1 <= level;
	end

	// saturate and look up duty and pulse count, then scale the duty
	logic [LVL_W-1:0]   sat_lvl;
	logic [MAP_W-1:0]   duty_map;
	logic [PULSE_W-1:0] pulses_map;

	always_comb begin
		sat_lvl    = (level_s1 > LEVEL_SAT) ? LEVEL_SAT : level_s1;
		duty_map   = (sat_lvl[LVL_W-1:MAP_W] == '0) ? DUTY_LUT[sat_lvl[MAP_W-1:0]] : '0;
		pulses_map = (sat_lvl[LVL_W-1:6] == '0) ? PULSE_LUT[sat_lvl[5:0]] : PULSE_W'(1);
	end

	// stage 2: mapped values and scaled product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (load_s2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			byp_s2    <= !line_present_q;
			off_s2    <= (level_s1 == '0);
			big_s2    <= (duty_map > CMD_SCALE_TH);
			duty_s2   <= line_present_q ? DUTY_W'(duty_map) : level_s1;
			pulses_s2 <= pulses_map;
			prod_s2   <= PROD_W'(duty_map) * PROD_W'(scale_q);
		end
	end

	// divide by 100 and saturate the command above the scale threshold; compare with the history
	logic [MULT_W-1:0] recip_prod;
	logic [QUOT_W-1:0] quot;
	logic [CMD_W-1:0]  cmd_calc;
	logic              pulse_new;
	logic              cmd_new;

	always_comb begin
		recip_prod = MULT_W'(prod_s2) * MULT_W'(RECIP_100);
		quot       = recip_prod[RECIP_SH +: QUOT_W];
		if (!big_s2)
			cmd_calc = duty_s2[CMD_W-1:0];
		else if (quot[QUOT_W-1:CMD_W] != '0)
			cmd_calc = '1;
		else
			cmd_calc = quot[CMD_W-1:0];
		pulse_new = (pulses_s2 != last_pulse_q);
		cmd_new   = !was_on_q && (last_cmd_q != cmd_calc);
	end

	// result register and request history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			last_pulse_q <= '0;
			was_on_q     <= 1'b0;
			last_cmd_q   <= '0;
		end else if (out_adv) begin
			out_valid <= valid_s2;
			if (valid_s2 && !byp_s2) begin
				if (off_s2) begin
					last_pulse_q <= '0;
					was_on_q     <= 1'b0;
					last_cmd_q   <= '0;
				end else begin
					was_on_q <= 1'b1;
					if (pulse_new)
						last_pulse_q <= pulses_s2;
					if (cmd_new)
						last_cmd_q <= cmd_calc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s2) begin
			bypassed <= byp_s2;
			if (byp_s2) begin
				duty        <= duty_s2;
				enable_line <= 1'b0;
				pulse_count <= '0;
				cmd_valid   <= 1'b0;
				cmd_value   <= '0;
			end else if (off_s2) begin
				duty        <= '0;
				enable_line <= 1'b0;
				pulse_count <= '0;
				cmd_valid   <= 1'b0;
				cmd_value   <= '0;
			end else begin
				duty        <= duty_s2;
				enable_line <= 1'b1;
				pulse_count <= pulse_new ? pulses_s2 : '0;
				cmd_valid   <= cmd_new;
				cmd_value   <= cmd_new ? cmd_calc : '0;
			end
		end
	end

endmodule

// File: src/bl2d_checker.sv
// bl2d_checker: port-level checks on the result channel of backlight_level_to_drive
// depends on bl2d_pkg; bound to backlight_level_to_drive at the end of this file
module bl2d_checker
	import bl2d_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [DUTY_W-1:0]  duty,
	input logic               enable_line,
	input logic [PULSE_W-1:0] pulse_count,
	input logic               cmd_valid,
	input logic [CMD_W-1:0]   cmd_value,
	input logic               bypassed
);

	// a bypassed request drives no enable line, pulses or command
	a_bypass_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bypassed |-> !enable_line && pulse_count == '0 && !cmd_valid)
		else $error("bypassed request drove the line");

	// a command or pulses go out only with the line enabled
	a_drive_needs_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (cmd_valid || pulse_count != '0) |-> enable_line)
		else $error("pulses or command with enable line low");

	// command value is zero when no command is issued
	a_cmd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cmd_valid |-> cmd_value == '0)
		else $error("cmd_value nonzero without cmd_valid");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duty) && $stable(pulse_count)
			&& $stable(cmd_value))
		else $error("stalled result changed");

endmodule

bind backlight_level_to_drive bl2d_checker u_bl2d_checker (.*);

// File: test/tb_backlight_level_to_drive.sv
// tb_backlight_level_to_drive: self-checking regression for backlight_level_to_drive
// drives level requests with random gaps and output stalls, predicts each drive result
// and compares it field by field; depends on bl2d_pkg and the block itself
module tb_backlight_level_to_drive;
	import bl2d_pkg::*;

	localparam logic [2:0] REG_LINE_PRESENT = 3'h0;
	localparam logic [2:0] REG_CMD_SCALE    = 3'h4;
	localparam int NUM_PHASES  = 12;
	localparam int PHASE_ITEMS = 77;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_LEN    = 80;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN       = 8;

	// directed levels: ramp edges, saturation, off, turn-on after off
	localparam int DIR_COUNT = 13;
	localparam int DIR_LEVELS [DIR_COUNT] = '{1, 1, 9, 10, 36, 37, 102, 103, 248, 249, 1023,
		0, 512};

	typedef struct packed {
		logic [DUTY_W-1:0]  duty;
		logic               enable_line;
		logic [PULSE_W-1:0] pulse_count;
		logic               cmd_valid;
		logic [CMD_W-1:0]   cmd_value;
		logic               bypassed;
	} drive_t;

	typedef struct {
		logic [LVL_W-1:0] lvl;
		int               gap;
	} level_req_t;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               psel        = 1'b0;
	logic               penable     = 1'b0;
	logic               pwrite      = 1'b0;
	logic [2:0]         paddr       = '0;
	logic [31:0]        pwdata      = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [LVL_W-1:0]   level       = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic [DUTY_W-1:0]  duty;
	logic               enable_line;
	logic [PULSE_W-1:0] pulse_count;
	logic               cmd_valid;
	logic [CMD_W-1:0]   cmd_value;
	logic               bypassed;

	backlight_level_to_drive dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.level       (level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.duty        (duty),
		.enable_line (enable_line),
		.pulse_count (pulse_count),
		.cmd_valid   (cmd_valid),
		.cmd_value   (cmd_value),
		.bypassed    (bypassed)
	);

	// predictor copy of the registers and the drive history
	logic               cfg_line  = 1'b1;
	logic [SCALE_W-1:0] cfg_scale = SCALE_RST;
	logic [PULSE_W-1:0] prev_pulses = '0;
	logic               lit         = 1'b0;
	logic [CMD_W-1:0]   pend_cmd    = '0;
	logic [CMD_W-1:0]   sent_cmd    = '0;

	level_req_t level_q[$];
	drive_t     drive_q[$];

	int n_sent    = 0;
	int n_results = 0;
	int n_writes  = 0;
	int n_errors  = 0;

	// one-wire pulse ramp over the low levels
	function automatic int pulses_at(input int lv);
		if (lv >= 1 && lv <= 9)
			return (320 - 16 * lv) / 10;
		if (lv >= 10 && lv <= 36)
			return (23140 - 615 * lv) / 1000;
		return 1;
	endfunction

	// piecewise-linear pwm duty
	function automatic int duty_at(input int lv);
		if (lv >= 1 && lv <= 36)
			return 26;
		if (lv > 36 && lv <= 102)
			return (489 * lv + 7000) / 1000 + 1;
		if (lv > 102 && lv <= 255)
			return (111 * lv - 5633) / 100 + 1;
		return 0;
	endfunction

	// expected drive for one level request, advancing the history
	function automatic drive_t drive_for_level(input logic [LVL_W-1:0] raw);
		drive_t r;
		int     lv;
		int     p;
		int     d;
		int     c;
		r = '0;
		if (!cfg_line) begin
			r.duty     = raw;
			r.bypassed = 1'b1;
		end else if (raw == 0) begin
			prev_pulses = '0;
			lit         = 1'b0;
			pend_cmd    = '0;
			sent_cmd    = '0;
		end else begin
			lv = (raw > LEVEL_MAX_DEF) ? LEVEL_MAX_DEF : int'(raw);
			p  = pulses_at(lv);
			d  = duty_at(lv);
			c  = d;
			if (d > 32) begin
				c = d * int'(cfg_scale) / 100;
				if (c > 255)
					c = 255;
			end
			pend_cmd = CMD_W'(c);
			r.duty   = DUTY_W'(d);
			if (PULSE_W'(p) != prev_pulses) begin
				r.pulse_count = PULSE_W'(p);
				prev_pulses   = PULSE_W'(p);
			end
			if (!lit && sent_cmd != pend_cmd) begin
				r.cmd_valid = 1'b1;
				r.cmd_value = pend_cmd;
				sent_cmd    = pend_cmd;
			end
			lit           = 1'b1;
			r.enable_line = 1'b1;
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			n_errors++;
		end
	endfunction

	// level mix: off, repeats, pulse ramp, duty ramp, saturation, anything
	function automatic logic [LVL_W-1:0] pick_level(input logic [LVL_W-1:0] prev);
		int k;
		k = $urandom_range(0, 99);
		if (k < 10)
			return '0;
		if (k < 20)
			return prev;
		if (k < 50)
			return LVL_W'($urandom_range(1, 40));
		if (k < 75)
			return LVL_W'($urandom_range(41, 255));
		if (k < 88)
			return LVL_W'($urandom_range(248, 1023));
		return LVL_W'($urandom_range(0, 1023));
	endfunction

	function automatic void queue_level(input logic [LVL_W-1:0] lvl, input int gap);
		level_req_t q;
		q.lvl = lvl;
		q.gap = gap;
		level_q.push_back(q);
	endfunction

	// apb write: setup then access, model copy follows at the write edge
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (addr)
			REG_LINE_PRESENT: cfg_line  = val[0];
			REG_CMD_SCALE:    cfg_scale = val[SCALE_W-1:0];
			default: ;
		endcase
		n_writes++;
	endtask

	// every request sent and every result back
	task automatic wait_idle();
		while (level_q.size() != 0 || in_valid || drive_q.size() != 0)
			@(posedge clk);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// request driver: each item carries its own gap before it is offered
	int gap_left = 0;
	always @(posedge clk) begin : drive_proc
		level_req_t nxt;
		if (in_valid && !in_stall) begin
			drive_q.push_back(drive_for_level(level));
			n_sent++;
			if (level_q.size() != 0 && level_q[0].gap == 0) begin
				nxt = level_q.pop_front();
				level <= nxt.lvl;
			end else begin
				in_valid <= 1'b0;
				gap_left = (level_q.size() != 0) ? level_q[0].gap - 1 : 0;
			end
		end else if (!in_valid && arst_n) begin
			if (gap_left > 0)
				gap_left--;
			else if (level_q.size() != 0) begin
				nxt = level_q.pop_front();
				level    <= nxt.lvl;
				in_valid <= 1'b1;
			end
		end
	end

	// result monitor and receiver stalls, with one long hold-off
	int stall_left = 0;
	int hold_left  = 0;
	always @(posedge clk) begin : rx_proc
		drive_t want;
		int     draw;
		if (out_valid && !out_stall) begin
			if (drive_q.size() == 0) begin
				$display("%0t: result with no request pending, expected none got duty %0d",
					$time, duty);
				n_errors++;
			end else begin
				want = drive_q.pop_front();
				check_field("duty", 32'(want.duty), 32'(duty));
				check_field("enable_line", 32'(want.enable_line), 32'(enable_line));
				check_field("pulse_count", 32'(want.pulse_count), 32'(pulse_count));
				check_field("cmd_valid", 32'(want.cmd_valid), 32'(cmd_valid));
				check_field("cmd_value", 32'(want.cmd_value), 32'(cmd_value));
				check_field("bypassed", 32'(want.bypassed), 32'(bypassed));
			end
			n_results++;
			if (n_results == HOLD_AT)
				hold_left = HOLD_LEN;
			draw       = ((n_results / 128) % 3 == 2) ? 0 : $urandom_range(0, 10);
			stall_left = draw;
		end else if (hold_left > 0)
			hold_left--;
		else if (stall_left > 0)
			stall_left--;
		out_stall <= (hold_left > 0) || (stall_left > 0);
	end

	// watchdog on cycles with no transfer on any port
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("backlight_level_to_drive regression: fail");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [LVL_W-1:0] lv;
		bit               busy;
		int               scale;
		lv = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: ramp edges, saturation, off, turn-on after off
		write_reg(REG_LINE_PRESENT, 32'd1);
		write_reg(REG_CMD_SCALE, 32'd90);
		for (int i = 0; i < DIR_COUNT; i++)
			queue_level(LVL_W'(DIR_LEVELS[i]), $urandom_range(0, 3));
		wait_idle();

		// line absent: raw pass-through, history kept for the next request
		write_reg(REG_LINE_PRESENT, 32'd0);
		queue_level(LVL_W'(0), 0);
		queue_level(LVL_W'(1023), 0);
		queue_level(LVL_W'(341), 2);
		wait_idle();
		write_reg(REG_LINE_PRESENT, 32'd1);
		queue_level(LVL_W'(512), 1);
		queue_level(LVL_W'(0), 0);
		wait_idle();

		// zero scale: scaled turn-on command of zero is suppressed, low duty unscaled
		write_reg(REG_CMD_SCALE, 32'd0);
		queue_level(LVL_W'(100), 0);
		queue_level(LVL_W'(0), 0);
		queue_level(LVL_W'(20), 0);
		wait_idle();

		// scale above 100 saturates the command
		write_reg(REG_CMD_SCALE, 32'd127);
		queue_level(LVL_W'(0), 0);
		queue_level(LVL_W'(248), 0);
		wait_idle();

		// random phases, each with its own register settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: scale = 0;
				1: scale = 127;
				2: scale = 100;
				3: scale = 1;
				default: scale = $urandom_range(0, 127);
			endcase
			write_reg(REG_LINE_PRESENT, (p == 6) ? 32'd0 : 32'($urandom_range(0, 7) != 0));
			write_reg(REG_CMD_SCALE, 32'(scale));
			busy = (p % 3 == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				lv = pick_level(lv);
				queue_level(lv, busy ? 0 : $urandom_range(0, 10));
			end
		end

		wait_idle();
		repeat (DRAIN) @(posedge clk);
		$display("%0d level requests, %0d results checked, %0d register writes, %0d mismatches",
			n_sent, n_results, n_writes, n_errors);
		$display("covered ramps, saturation, off and turn-on, bypass, scale 0 to 127, output hold");
		if (n_errors == 0 && drive_q.size() == 0)
			$display("backlight_level_to_drive regression: pass");
		else
			$display("backlight_level_to_drive regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
src/bl2d_pkg.sv
src/backlight_level_to_drive.sv
src/bl2d_checker.sv
test/tb_backlight_level_to_drive.sv
